// File: sv/ebsl_pkg.sv
package ebsl_pkg;

    localparam int ROW_W     = 12;
    localparam int COL_W     = 6;
    localparam int WEIGHT_W  = 16;
    localparam int LEN_W     = 7;
    localparam int ELEM_W    = 24;
    localparam int ACC_W     = 32;
    localparam int SCALE_W   = 17;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int ROW_SPAN  = 2 ** ROW_W;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic
    {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t                    kind;
        logic                         in_range;
        logic                         last;
        logic [COL_W-1:0]             k_last;
        logic [ADDR_W-1:0]            addr;
        logic signed [WEIGHT_W-1:0]   weight;
    } cmd_t;

    // round(65536 / sqrt(n)), evaluated at elaboration only
    function automatic logic [SCALE_W-1:0] scale_of(input int unsigned n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned nn;
        lo = 64'd0;
        hi = 64'd65536;
        nn = longint'(n);
        for (int i = 0; i < 18; i++)
        begin
            mid = (lo + hi + 64'd1) / 2;
            if (lo < hi)
            begin
                if (mid * mid * nn <= (64'd1 << 32))
                    lo = mid;
                else
                    hi = mid - 64'd1;
            end
        end
        if ((64'd2 * lo + 64'd1) * (64'd2 * lo + 64'd1) * nn <= (64'd1 << 34))
            lo = lo + 64'd1;
        return SCALE_W'(lo);
    endfunction

endpackage

// File: sv/ebsl_front.sv
module ebsl_front #(
    parameter int TABLE_ROWS = 4096,
    parameter int MAX_DIM    = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ebsl_pkg::LEN_W-1:0]    cfg_wr_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ebsl_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,
    input  logic                          s_axis_tuser,
    output logic                          push_valid,
    input  logic                          push_ready,
    output ebsl_pkg::cmd_t                push_data
);
    import ebsl_pkg::*;

    localparam int ROWS_USED = (TABLE_ROWS < ROW_SPAN) ? TABLE_ROWS : ROW_SPAN;

    logic [LEN_W-1:0]           vector_length_reg;
    logic [LEN_W-1:0]           vector_length_next;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           column;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       row_ok;
    logic                       col_ok;
    logic [ADDR_W-1:0]          base_addr;
    logic [COL_W-1:0]           k_last;

    always_comb
    begin
        vector_length_next = vector_length_reg;
        if (cfg_wr_en)
            vector_length_next = cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vector_length_reg <= LEN_W'(16);
        else
            vector_length_reg <= vector_length_next;
    end

    assign row    = s_axis_tdata[ROW_W-1:0];
    assign column = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
    assign weight = s_axis_tdata[ROW_W+COL_W+WEIGHT_W-1:ROW_W+COL_W];

    assign row_ok    = ({1'b0, row} < (ROW_W+1)'(ROWS_USED));
    assign col_ok    = ({1'b0, column} < (COL_W+1)'(MAX_DIM));
    assign base_addr = ADDR_W'(32'(row) * 32'(MAX_DIM));

    // clamp the length register into 1..MAX_DIM, kept as last index
    always_comb
    begin
        priority if (vector_length_reg == '0)
            k_last = '0;
        else if (vector_length_reg > LEN_W'(MAX_DIM))
            k_last = COL_W'(MAX_DIM - 1);
        else
            k_last = COL_W'(vector_length_reg - LEN_W'(1));
    end

    always_comb
    begin
        push_data.kind   = cmd_kind_t'(s_axis_tuser);
        push_data.last   = s_axis_tlast;
        push_data.k_last = k_last;
        push_data.weight = weight;
        if (push_data.kind == CMD_WRITE)
        begin
            push_data.in_range = row_ok && col_ok;
            push_data.addr     = base_addr + ADDR_W'(column);
        end
        else
        begin
            push_data.in_range = row_ok;
            push_data.addr     = base_addr;
        end
    end

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

endmodule

// File: sv/ebsl_queue.sv
module ebsl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  ebsl_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ebsl_pkg::cmd_t pop_data
);
    import ebsl_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + FILL_W'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - FILL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: sv/ebsl_back.sv
module ebsl_back #(
    parameter int TABLE_ROWS = 4096,
    parameter int MAX_DIM    = 64,
    parameter int MAX_BAG    = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  ebsl_pkg::cmd_t                pop_data,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ebsl_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    output logic                          m_axis_tuser
);
    import ebsl_pkg::*;

    localparam int ROWS_USED = (TABLE_ROWS < ROW_SPAN) ? TABLE_ROWS : ROW_SPAN;
    localparam int DEPTH     = ROWS_USED * MAX_DIM;
    localparam int AW        = $clog2(DEPTH);
    localparam int KW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW        = $clog2(MAX_BAG + 1);
    localparam int SW        = (MAX_BAG > 1) ? $clog2(MAX_BAG) : 1;
    localparam int PROD_W    = ACC_W + SCALE_W + 1;

    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_ACC   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    cmd_t                       cmd_reg;
    cmd_t                       cmd_next;
    logic [KW-1:0]              k_reg;
    logic [KW-1:0]              k_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [CW-1:0]              count_m1;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic [MAX_DIM-1:0]         acc_vld_reg;
    logic [MAX_DIM-1:0]         acc_vld_next;
    logic                       l1_vld_reg;
    logic                       l1_vld_next;
    logic [KW-1:0]              l1_k_reg;
    logic                       p1_vld_reg;
    logic                       p2_vld_reg;
    logic                       out_vld_reg;

    logic signed [WEIGHT_W-1:0] tab_mem [DEPTH];
    logic signed [WEIGHT_W-1:0] tab_rdata_reg;
    logic signed [ACC_W-1:0]    acc_mem [MAX_DIM];
    logic signed [ACC_W-1:0]    acc_rdata_reg;
    logic                       acc_rvld_reg;
    logic [SCALE_W-1:0]         scale_rom [MAX_BAG];
    logic [SCALE_W-1:0]         scale_reg;

    logic [COL_W-1:0]           p1_idx_reg;
    logic                       p1_last_reg;
    logic signed [PROD_W-1:0]   p2_prod_reg;
    logic [COL_W-1:0]           p2_idx_reg;
    logic                       p2_last_reg;
    logic signed [ELEM_W-1:0]   out_elem_reg;
    logic [COL_W-1:0]           out_idx_reg;
    logic                       out_last_reg;
    logic                       out_ovf_reg;

    logic                       tab_we;
    logic                       tab_re;
    logic [AW-1:0]              tab_raddr;
    logic                       acc_re;
    logic                       scale_ld;
    logic                       emit_issue;
    logic                       adv;
    logic                       k_at_end;
    logic signed [ACC_W-1:0]    acc_val;
    logic signed [ACC_W:0]      acc_sum;
    logic signed [ACC_W-1:0]    acc_sat;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic signed [PROD_W-17:0]  elem_wide;
    logic signed [ELEM_W-1:0]   elem_sat;

    for (genvar g = 0; g < MAX_BAG; g++)
    begin : g_scale
        assign scale_rom[g] = scale_of(g + 1);
    end

    assign adv       = !out_vld_reg || m_axis_tready;
    assign k_at_end  = (k_reg == cmd_reg.k_last[KW-1:0]);
    assign tab_raddr = cmd_reg.addr[AW-1:0] + AW'(k_reg);
    assign count_m1  = count_reg - CW'(1);
    assign acc_val   = acc_rvld_reg ? acc_rdata_reg : '0;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        k_next       = k_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        acc_vld_next = acc_vld_reg;
        pop_ready    = 1'b0;
        tab_we       = 1'b0;
        tab_re       = 1'b0;
        acc_re       = 1'b0;
        l1_vld_next  = 1'b0;
        scale_ld     = 1'b0;
        emit_issue   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    if (pop_data.kind == CMD_WRITE)
                        tab_we = pop_data.in_range;
                    else
                    begin
                        cmd_next = pop_data;
                        k_next   = '0;
                        if (count_reg != CW'(MAX_BAG))
                            count_next = count_reg + CW'(1);
                        else
                            ovf_next = 1'b1;
                        state_next = pop_data.in_range ? ST_ACC : ST_DRAIN;
                    end
                end
            end
            ST_ACC:
            begin
                tab_re      = 1'b1;
                acc_re      = 1'b1;
                l1_vld_next = 1'b1;
                if (k_at_end)
                    state_next = ST_DRAIN;
                else
                    k_next = k_reg + KW'(1);
            end
            ST_DRAIN:
            begin
                scale_ld   = 1'b1;
                k_next     = '0;
                state_next = cmd_reg.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (adv)
                begin
                    acc_re     = 1'b1;
                    emit_issue = 1'b1;
                    if (k_at_end)
                        state_next = ST_FLUSH;
                    else
                        k_next = k_reg + KW'(1);
                end
            end
            ST_FLUSH:
            begin
                if (!p1_vld_reg && !p2_vld_reg)
                begin
                    acc_vld_next = '0;
                    count_next   = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (l1_vld_reg)
            acc_vld_next[l1_k_reg] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cmd_reg     <= '0;
            k_reg       <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            acc_vld_reg <= '0;
            l1_vld_reg  <= 1'b0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            k_reg       <= k_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            acc_vld_reg <= acc_vld_next;
            l1_vld_reg  <= l1_vld_next;
            if (adv)
            begin
                p1_vld_reg  <= emit_issue;
                p2_vld_reg  <= p1_vld_reg;
                out_vld_reg <= p2_vld_reg;
            end
        end
    end

    // embedding table
    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_mem[pop_data.addr[AW-1:0]] <= pop_data.weight;
        if (tab_re)
            tab_rdata_reg <= tab_mem[tab_raddr];
    end

    // saturating accumulate of one element
    always_comb
    begin
        acc_sum = {acc_val[ACC_W-1], acc_val} +
                  {{(ACC_W+1-WEIGHT_W){tab_rdata_reg[WEIGHT_W-1]}}, tab_rdata_reg};
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            acc_sat = acc_sum[ACC_W-1:0];
    end

    // accumulators
    always_ff @(posedge clk)
    begin
        if (l1_vld_reg)
            acc_mem[l1_k_reg] <= acc_sat;
        if (acc_re)
        begin
            acc_rdata_reg <= acc_mem[k_reg];
            acc_rvld_reg  <= acc_vld_reg[k_reg];
        end
    end

    // round half up to Q12.12 and saturate
    always_comb
    begin
        prod_rnd  = p2_prod_reg + PROD_W'(32768);
        elem_wide = prod_rnd[PROD_W-1:16];
        if (elem_wide > (PROD_W-16)'(8388607))
            elem_sat = {1'b0, {(ELEM_W-1){1'b1}}};
        else if (elem_wide < -(PROD_W-16)'(8388608))
            elem_sat = {1'b1, {(ELEM_W-1){1'b0}}};
        else
            elem_sat = elem_wide[ELEM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (scale_ld)
            scale_reg <= scale_rom[count_m1[SW-1:0]];
        l1_k_reg <= k_reg;
        if (adv)
        begin
            if (emit_issue)
            begin
                p1_idx_reg  <= COL_W'(k_reg);
                p1_last_reg <= k_at_end;
            end
            p2_prod_reg <= PROD_W'(acc_val) * PROD_W'($signed({1'b0, scale_reg}));
            p2_idx_reg  <= p1_idx_reg;
            p2_last_reg <= p1_last_reg;
            if (p2_vld_reg)
            begin
                out_elem_reg <= elem_sat;
                out_idx_reg  <= p2_idx_reg;
                out_last_reg <= p2_last_reg;
                out_ovf_reg  <= ovf_reg;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(M_DATA_W-ELEM_W-COL_W){1'b0}}, out_idx_reg, out_elem_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule

// File: sv/embedding_bag_sqrtn_lookup_core.sv
// embedding bag engine with 1/sqrt(n) combiner
// s_axis carries table writes and feature lookups, one transfer per item;
// tuser = 0 writes weight at (row, column), tuser = 1 adds row into the bag,
// tlast on a lookup closes the bag
// m_axis gives vector_length elements per closed bag, tlast on the final
// one and tuser set when the bag held more than MAX_BAG features
// cfg_wr_en / cfg_wr_data load vector_length (reset value 16)
// items are decoded and queued two deep, so s_axis keeps taking transfers
// while the execution side works or m_axis is stalled
// a write is done in the idle state of the execution side; a lookup
// passes the idle, accumulate and drain states, with one table and one
// accumulator read per cycle while accumulating; closing a bag adds an emission pass through a
// three-stage scale pipeline; m_axis back-pressure halts that pipeline
// and, once the queue is full, s_axis tready drops
// reset clears the accumulators at once through per-entry valid bits,
// with no clearing pass; table contents are undefined until written
module embedding_bag_sqrtn_lookup_core #(
    parameter int TABLE_ROWS = 4096,
    parameter int MAX_DIM    = 64,
    parameter int MAX_BAG    = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ebsl_pkg::LEN_W-1:0]    cfg_wr_data,   // vector_length
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ebsl_pkg::S_DATA_W-1:0] s_axis_tdata,  // row, column, weight
    input  logic                          s_axis_tlast,  // last_feature
    input  logic                          s_axis_tuser,  // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ebsl_pkg::M_DATA_W-1:0] m_axis_tdata,  // element, element_index
    output logic                          m_axis_tlast,  // last_element
    output logic                          m_axis_tuser   // bag_overflow
);
    import ebsl_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    ebsl_front #(
        .TABLE_ROWS (TABLE_ROWS),
        .MAX_DIM    (MAX_DIM)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    ebsl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ebsl_back #(
        .TABLE_ROWS (TABLE_ROWS),
        .MAX_DIM    (MAX_DIM),
        .MAX_BAG    (MAX_BAG)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
